// ===== src/ihq_pkg.sv =====
// ============================================================================
// ihq_pkg: shared codes and fixed widths of the indexed max-heap queue
// Operation and status codes, plus the field widths of the stream items.
// ============================================================================
package ihq_pkg;

    localparam int unsigned OP_BITS     = 2;
    localparam int unsigned ID_BITS     = 10;
    localparam int unsigned KEY_IN_BITS = 32;
    localparam int unsigned STAT_BITS   = 2;
    localparam int unsigned CNT_BITS    = 11;

    typedef enum logic [OP_BITS-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_POP    = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [STAT_BITS-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_ABSENT  = 2'd3
    } status_t;

endpackage

// ===== src/ihq_ram.sv =====
// ============================================================================
// ihq_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ============================================================================
module ihq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/indexed_max_heap_queue.sv =====
// ============================================================================
// indexed_max_heap_queue: indexed binary max-heap priority queue
// Heap of (id, key) pairs with a per-id slot map for removal by id.
// ============================================================================
// Usage. Each input item on the s_ channel carries an operation (insert,
// remove by id, pop largest), an item id and a key. Every input item yields
// exactly one result item on the m_ channel with a status, the popped id and
// key (zero unless a pop succeeds) and the number of queued entries after it.
// Items are handled one at a time. An item passes through the lookup or removal
// states that its op needs, then the sift: sift up takes one S_UP step per level,
// sift down the S_DN_L and S_DN_R steps per level (the two children come one after
// the other through the single heap read port), and an insert that first
// removes an older copy of its id runs that removal before its own insert.
// After reset the slot map is swept clear, one id per cycle, and s_tready
// stays low during that sweep. The result sits in an output register, so a
// new item is accepted while a result still waits; if the receiver stalls,
// the following result is held until the register frees, and the block
// then stops accepting items.
// ============================================================================
module indexed_max_heap_queue
    import ihq_pkg::*;
#(
    parameter int unsigned CAPACITY = 1024,
    parameter int unsigned ID_SPACE = 1024,
    parameter int unsigned KEY_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] op, [11:2] item_id, [43:12] item_key, [47:44] zero
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [11:2] out_id, [43:12] out_key, [54:44] entry_count,
    // [55] zero
    output logic [55:0] m_tdata
);

    // Stored key width: keys are taken to KEY_BITS, the port carries 32.
    localparam int unsigned KW  = (KEY_BITS < KEY_IN_BITS) ? KEY_BITS : KEY_IN_BITS;
    localparam int unsigned EW  = ID_BITS + KW;           // heap entry {id, key}
    localparam int unsigned SW  = $clog2(CAPACITY);       // heap slot index
    localparam int unsigned CW  = $clog2(CAPACITY + 1);   // entry count
    localparam int unsigned JW  = SW + 1;                 // child index before check
    localparam int unsigned IDW = $clog2(ID_SPACE);       // slot map address

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_LOOK, S_RM_B, S_RM_C, S_UP, S_DN_L, S_DN_R, S_FIN, S_INS,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [ID_BITS-1:0]  id_reg, id_next;
    logic [KW-1:0]       key_reg, key_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [SW-1:0]       k_reg, k_next;
    logic [SW-1:0]       h_reg, h_next;
    logic [SW-1:0]       j_reg, j_next;
    logic [EW-1:0]       mv_reg, mv_next;
    logic [EW-1:0]       child_reg, child_next;
    logic                has_r_reg, has_r_next;
    logic                strict_reg, strict_next;
    logic                ret_ins_reg, ret_ins_next;
    logic                is_pop_reg, is_pop_next;
    status_t             status_reg, status_next;
    logic [ID_BITS-1:0]  res_id_reg, res_id_next;
    logic [KW-1:0]       res_key_reg, res_key_next;
    logic [IDW-1:0]      clr_reg, clr_next;
    logic                m_valid_reg, m_valid_next;
    logic [55:0]         m_data_reg, m_data_next;

    // Memory ports.
    logic                heap_we, heap_re;
    logic [SW-1:0]       heap_waddr, heap_raddr;
    logic [EW-1:0]       heap_wdata, heap_rdata;
    logic                slot_we;
    logic [IDW-1:0]      slot_waddr, slot_raddr;
    logic [SW:0]         slot_wdata, slot_rdata;

    // Start of a sift-down step, shared by several states.
    logic                dn_go;
    logic [SW-1:0]       dn_pos;
    logic [JW-1:0]       dn_j;

    logic                s_acc;
    op_t                 s_op;
    logic [ID_BITS-1:0]  s_id;
    logic [KW-1:0]       s_key;
    logic [EW-1:0]       pick;
    logic [SW-1:0]       pick_j;
    logic [SW-1:0]       par_k;
    logic                up_move;

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign s_op     = op_t'(s_tdata[1:0]);
    assign s_id     = s_tdata[11:2];
    assign s_key    = KW'(s_tdata[43:12]);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign par_k = SW'((k_reg - SW'(1)) >> 1);

    ihq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap (
        .aclk(aclk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
        .raddr(heap_raddr), .rdata(heap_rdata)
    );

    ihq_ram #(.WIDTH(SW + 1), .DEPTH(ID_SPACE)) u_slot (
        .aclk(aclk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
        .raddr(slot_raddr), .rdata(slot_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        id_next      = id_reg;
        key_next     = key_reg;
        count_next   = count_reg;
        k_next       = k_reg;
        h_next       = h_reg;
        j_next       = j_reg;
        mv_next      = mv_reg;
        child_next   = child_reg;
        has_r_next   = has_r_reg;
        strict_next  = strict_reg;
        ret_ins_next = ret_ins_reg;
        is_pop_next  = is_pop_reg;
        status_next  = status_reg;
        res_id_next  = res_id_reg;
        res_key_next = res_key_reg;
        clr_next     = clr_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;

        heap_we    = 1'b0;
        heap_re    = 1'b0;
        heap_waddr = k_reg;
        heap_wdata = mv_reg;
        heap_raddr = '0;
        slot_we    = 1'b0;
        slot_waddr = '0;
        slot_wdata = '0;
        slot_raddr = IDW'(id_reg);

        dn_go  = 1'b0;
        dn_pos = k_reg;
        pick   = child_reg;
        pick_j = j_reg;
        up_move = 1'b0;

        unique case (state_reg)
            S_CLR: begin
                slot_we    = 1'b1;
                slot_waddr = clr_reg;
                slot_wdata = '0;
                clr_next   = clr_reg + IDW'(1);
                if (clr_reg == IDW'(ID_SPACE - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                slot_raddr = IDW'(s_id);
                if (s_acc) begin
                    op_next      = s_op;
                    id_next      = s_id;
                    key_next     = s_key;
                    status_next  = ST_OK;
                    res_id_next  = '0;
                    res_key_next = '0;
                    ret_ins_next = 1'b0;
                    is_pop_next  = 1'b0;
                    unique case (s_op)
                        OP_INSERT, OP_REMOVE: begin
                            if (32'(s_id) >= ID_SPACE) begin
                                status_next = ST_ABSENT;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_LOOK;
                            end
                        end
                        OP_POP: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end else begin
                                h_next      = '0;
                                heap_re     = 1'b1;
                                heap_raddr  = '0;
                                is_pop_next = 1'b1;
                                state_next  = S_RM_B;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_LOOK: begin
                if (slot_rdata[SW]) begin
                    h_next       = slot_rdata[SW-1:0];
                    heap_re      = 1'b1;
                    heap_raddr   = slot_rdata[SW-1:0];
                    ret_ins_next = (op_reg == OP_INSERT);
                    state_next   = S_RM_B;
                end else if (op_reg == OP_INSERT) begin
                    state_next = S_INS;
                end else begin
                    status_next = ST_ABSENT;
                    state_next  = S_DONE;
                end
            end
            S_RM_B: begin
                // Victim entry is on the read port: unmap its id.
                if (is_pop_reg) begin
                    res_id_next  = heap_rdata[EW-1:KW];
                    res_key_next = heap_rdata[KW-1:0];
                end
                slot_we    = 1'b1;
                slot_waddr = IDW'(heap_rdata[EW-1:KW]);
                slot_wdata = '0;
                count_next = count_reg - CW'(1);
                if (h_reg == SW'(count_reg - CW'(1))) begin
                    state_next = ret_ins_reg ? S_INS : S_DONE;
                end else begin
                    heap_re    = 1'b1;
                    heap_raddr = SW'(count_reg - CW'(1));
                    state_next = S_RM_C;
                end
            end
            S_RM_C: begin
                // The last entry fills the hole and then moves up or down.
                mv_next = heap_rdata;
                k_next  = h_reg;
                if (h_reg == '0) begin
                    dn_go  = 1'b1;
                    dn_pos = h_reg;
                end else begin
                    heap_re     = 1'b1;
                    heap_raddr  = SW'((h_reg - SW'(1)) >> 1);
                    strict_next = 1'b1;
                    state_next  = S_UP;
                end
            end
            S_UP: begin
                // The first compare after a removal is strict; later ones let
                // the moving entry pass equal keys.
                if (strict_reg) begin
                    up_move = heap_rdata[KW-1:0] < mv_reg[KW-1:0];
                end else begin
                    up_move = heap_rdata[KW-1:0] <= mv_reg[KW-1:0];
                end
                strict_next = 1'b0;
                if (up_move) begin
                    heap_we    = 1'b1;
                    heap_waddr = k_reg;
                    heap_wdata = heap_rdata;
                    slot_we    = 1'b1;
                    slot_waddr = IDW'(heap_rdata[EW-1:KW]);
                    slot_wdata = {1'b1, k_reg};
                    k_next     = par_k;
                    if (par_k == '0) begin
                        state_next = S_FIN;
                    end else begin
                        heap_re    = 1'b1;
                        heap_raddr = SW'((par_k - SW'(1)) >> 1);
                    end
                end else if (strict_reg) begin
                    dn_go  = 1'b1;
                    dn_pos = k_reg;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_DN_L: begin
                child_next = heap_rdata;
                if ((JW'(j_reg) + JW'(1)) < JW'(count_reg)) begin
                    heap_re    = 1'b1;
                    heap_raddr = j_reg + SW'(1);
                    has_r_next = 1'b1;
                end else begin
                    has_r_next = 1'b0;
                end
                state_next = S_DN_R;
            end
            S_DN_R: begin
                // Right child wins ties between the children.
                if (has_r_reg && (child_reg[KW-1:0] <= heap_rdata[KW-1:0])) begin
                    pick   = heap_rdata;
                    pick_j = j_reg + SW'(1);
                end
                if (pick[KW-1:0] <= mv_reg[KW-1:0]) begin
                    state_next = S_FIN;
                end else begin
                    heap_we    = 1'b1;
                    heap_waddr = k_reg;
                    heap_wdata = pick;
                    slot_we    = 1'b1;
                    slot_waddr = IDW'(pick[EW-1:KW]);
                    slot_wdata = {1'b1, k_reg};
                    k_next     = pick_j;
                    dn_go      = 1'b1;
                    dn_pos     = pick_j;
                end
            end
            S_FIN: begin
                heap_we    = 1'b1;
                heap_waddr = k_reg;
                heap_wdata = mv_reg;
                slot_we    = 1'b1;
                slot_waddr = IDW'(mv_reg[EW-1:KW]);
                slot_wdata = {1'b1, k_reg};
                state_next = ret_ins_reg ? S_INS : S_DONE;
            end
            S_INS: begin
                ret_ins_next = 1'b0;
                if (count_reg >= CW'(CAPACITY)) begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end else begin
                    k_next     = SW'(count_reg);
                    count_next = count_reg + CW'(1);
                    mv_next    = {id_reg, key_reg};
                    if (count_reg == '0) begin
                        state_next = S_FIN;
                    end else begin
                        heap_re     = 1'b1;
                        heap_raddr  = SW'((SW'(count_reg) - SW'(1)) >> 1);
                        strict_next = 1'b0;
                        state_next  = S_UP;
                    end
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, CNT_BITS'(count_reg),
                                    KEY_IN_BITS'(res_key_reg), res_id_reg, status_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Descend from dn_pos: fetch its left child if it exists.
        dn_j = {dn_pos, 1'b1};
        if (dn_go) begin
            if (dn_j < JW'(count_reg)) begin
                heap_re    = 1'b1;
                heap_raddr = SW'(dn_j);
                j_next     = SW'(dn_j);
                state_next = S_DN_L;
            end else begin
                state_next = S_FIN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            count_reg   <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            ret_ins_reg <= 1'b0;
            is_pop_reg  <= 1'b0;
            strict_reg  <= 1'b0;
            has_r_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            ret_ins_reg <= ret_ins_next;
            is_pop_reg  <= is_pop_next;
            strict_reg  <= strict_next;
            has_r_reg   <= has_r_next;
        end
        op_reg      <= op_next;
        id_reg      <= id_next;
        key_reg     <= key_next;
        k_reg       <= k_next;
        h_reg       <= h_next;
        j_reg       <= j_next;
        mv_reg      <= mv_next;
        child_reg   <= child_next;
        status_reg  <= status_next;
        res_id_reg  <= res_id_next;
        res_key_reg <= res_key_next;
        m_data_reg  <= m_data_next;
    end

    // The queue never holds more than its capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= CAPACITY)
        else $error("entry count above capacity");

    // A heap read never needs data written to the same slot in that cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(heap_we && heap_re && (heap_waddr == heap_raddr)))
        else $error("heap read and write collide");

    // A result whose status is not OK reports a zero id and key.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg[1:0] != ST_OK)) |->
        ((m_data_reg[11:2] == '0) && (m_data_reg[43:12] == '0)))
        else $error("id or key reported without a pop");

    // A child under comparison lies inside the queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DN_R) |-> (JW'(j_reg) < JW'(count_reg)))
        else $error("sift down reads past the last entry");

endmodule

// ===== sim/tb_top.sv =====
// ============================================================================
// tb_top: self-checking testbench of the indexed max-heap queue
// Drives insert, remove and pop items, predicts each result with a software
// heap kept beside the block, and compares every result field by field.
// ============================================================================
module tb_top;
    import ihq_pkg::*;

    localparam int unsigned CAP   = 1024;
    localparam int unsigned IDS   = 1024;
    localparam int unsigned NRAND = 550;

    // Members run from the highest bits down, so status lands in bits [1:0].
    typedef struct packed {
        logic [10:0]      entry_count;
        logic [31:0]      out_key;
        logic [9:0]       out_id;
        status_t          status;
    } heap_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // [1:0] op, [11:2] item_id, [43:12] item_key, [47:44] zero
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // [1:0] status, [11:2] out_id, [43:12] out_key, [54:44] entry_count, [55] zero
    logic [55:0] m_tdata;

    indexed_max_heap_queue u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Predicted heap state, a private copy of what the block should hold.
    logic [31:0]  pq_keys [CAP];
    logic [9:0]   pq_ids  [CAP];
    int unsigned  pq_slot [IDS];
    bit           pq_held [IDS];
    int unsigned  pq_count;

    heap_result_t expected_results[$];
    int unsigned  error_count;
    bit           idle_enable;   // random gaps on both sides when set
    bit           sink_hold;     // long receiver hold-off request

    function automatic void pq_place(int unsigned s, logic [9:0] id, logic [31:0] key);
        pq_ids[s]  = id;
        pq_keys[s] = key;
        pq_slot[id] = s;
    endfunction

    function automatic void pq_sift_up(int unsigned k);
        logic [9:0]  id;
        logic [31:0] key;
        int unsigned par;
        id  = pq_ids[k];
        key = pq_keys[k];
        // A newcomer climbs above parents with an equal key.
        while (k != 0) begin
            par = (k - 1) / 2;
            if (!(pq_keys[par] <= key)) break;
            pq_place(k, pq_ids[par], pq_keys[par]);
            k = par;
        end
        pq_place(k, id, key);
    endfunction

    function automatic void pq_sift_down(int unsigned k);
        logic [9:0]  id;
        logic [31:0] key;
        int unsigned j;
        id  = pq_ids[k];
        key = pq_keys[k];
        // The right child wins a tie; stop when no child is strictly larger.
        while (k + 1 <= pq_count / 2) begin
            j = 2 * k + 1;
            if (j + 1 < pq_count && pq_keys[j] <= pq_keys[j + 1]) j = j + 1;
            if (pq_keys[j] <= key) break;
            pq_place(k, pq_ids[j], pq_keys[j]);
            k = j;
        end
        pq_place(k, id, key);
    endfunction

    function automatic void pq_remove_slot(int unsigned h);
        int unsigned last;
        last = pq_count - 1;
        pq_held[pq_ids[h]] = 1'b0;
        pq_slot[pq_ids[h]] = 0;
        if (h == last) begin
            pq_count = last;
        end else begin
            pq_place(h, pq_ids[last], pq_keys[last]);
            pq_count = last;
            if (h > 0 && pq_keys[(h - 1) / 2] < pq_keys[h]) pq_sift_up(h);
            else pq_sift_down(h);
        end
    endfunction

    function automatic heap_result_t pq_apply(op_t op, logic [9:0] id, logic [31:0] key);
        heap_result_t r;
        int unsigned  s;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_INSERT: begin
                // Re-inserting a queued id first drops the old copy.
                if (pq_held[id] && pq_slot[id] < pq_count) pq_remove_slot(pq_slot[id]);
                if (pq_count >= CAP) begin
                    r.status = ST_FULL;
                end else begin
                    s = pq_count;
                    pq_place(s, id, key);
                    pq_held[id] = 1'b1;
                    pq_count = s + 1;
                    pq_sift_up(s);
                end
            end
            OP_REMOVE: begin
                if (!pq_held[id] || pq_slot[id] >= pq_count) r.status = ST_ABSENT;
                else pq_remove_slot(pq_slot[id]);
            end
            OP_POP: begin
                if (pq_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.out_id  = pq_ids[0];
                    r.out_key = pq_keys[0];
                    pq_remove_slot(0);
                end
            end
            default: ;
        endcase
        r.entry_count = pq_count[10:0];
        return r;
    endfunction

    // Sends one item, waiting for acceptance; the prediction is made at the
    // accepting edge so it follows the block's order exactly. tvalid stays
    // high after acceptance until the next item or an idle cycle replaces it.
    task automatic send_item(op_t op, logic [9:0] id, logic [31:0] key);
        while (idle_enable && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, key, id, op};
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(pq_apply(op, id, key));
    endtask

    task automatic send_rand(int unsigned idspan);
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 45)      send_item(OP_INSERT, 10'($urandom_range(idspan - 1)), $urandom);
        else if (sel < 70) send_item(OP_REMOVE, 10'($urandom_range(idspan - 1)), $urandom);
        else if (sel < 97) send_item(OP_POP, 10'($urandom), $urandom);
        else               send_item(OP_NONE, 10'($urandom), $urandom);
    endtask

    // Receiver: random stalls plus an optional long hold-off, then checks.
    always @(posedge aclk) begin
        heap_result_t got;
        heap_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[54:0];
                if (expected_results.size() == 0) begin
                    $error("unexpected result item %h", m_tdata);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, got.status);
                        error_count++;
                    end
                    if (got.out_id !== want.out_id) begin
                        $error("out_id expected %0d actual %0d", want.out_id, got.out_id);
                        error_count++;
                    end
                    if (got.out_key !== want.out_key) begin
                        $error("out_key expected %0h actual %0h", want.out_key, got.out_key);
                        error_count++;
                    end
                    if (got.entry_count !== want.entry_count) begin
                        $error("entry_count expected %0d actual %0d",
                               want.entry_count, got.entry_count);
                        error_count++;
                    end
                end
            end
            m_tready <= !sink_hold && !(idle_enable && $urandom_range(99) < 16);
        end
    end

    task automatic test_edges();
        send_item(OP_POP, 10'd0, 32'd0);            // pop of an empty queue
        send_item(OP_REMOVE, 10'd5, 32'd0);         // remove of an absent id
        send_item(OP_NONE, 10'h3FF, 32'hFFFF_FFFF); // unused op code
        send_item(OP_INSERT, 10'd0, 32'd0);
        send_item(OP_INSERT, 10'h3FF, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 10'h155, 32'h5555_5555);
        send_item(OP_INSERT, 10'h2AA, 32'h5555_5555); // equal keys
        send_item(OP_INSERT, 10'd7, 32'hAAAA_AAAA);
        send_item(OP_INSERT, 10'h155, 32'd1);         // re-insert with a new key
        send_item(OP_REMOVE, 10'h3FF, 32'd0);
        send_item(OP_REMOVE, 10'h3FF, 32'd0);
        repeat (6) send_item(OP_POP, 10'd0, 32'd0);
    endtask

    task automatic test_fill();
        // Insert a burst with the receiver held back so the block stalls its
        // input, then drain the queue.
        fork
            begin
                sink_hold = 1'b1;
                repeat (400) @(posedge aclk);
                sink_hold = 1'b0;
            end
            for (int i = 0; i < 100; i++) send_item(OP_INSERT, 10'(i), $urandom_range(63));
        join
        send_item(OP_INSERT, 10'd3, 32'd9);      // re-insert of a queued id
        send_item(OP_INSERT, 10'd0, 32'd9);
        for (int i = 0; i < 20; i++) send_item(OP_REMOVE, 10'($urandom), 32'd0);
        while (pq_count > 0) send_item(OP_POP, 10'd0, 32'd0);
    endtask

    task automatic test_random();
        for (int i = 0; i < NRAND; i++) begin
            idle_enable = !(i >= 300 && i < 450);   // one stretch with no gaps
            send_rand(i < 350 ? 48 : IDS);
        end
        idle_enable = 1'b1;
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        idle_enable = 1'b1;
        sink_hold   = 1'b0;
        error_count = 0;
        pq_count    = 0;
        foreach (pq_held[i]) begin
            pq_held[i] = 1'b0;
            pq_slot[i] = 0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_edges();
        test_random();
        test_fill();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
